FILE: hw/rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// shared concurrent assertion macros for the pooling block checkers
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// assertion held off while reset is asserted
`define SPMSF_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// assertion that is also checked around reset
`define SPMSF_ASSERT_NR(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

FILE: hw/rtl/spmsf_pkg.sv
// ----------------------------------------------------------------------------
// spmsf_pkg
// types and constants of the segment pooling block
// ----------------------------------------------------------------------------
`default_nettype none

package spmsf_pkg;

  localparam int unsigned MaxWidth  = 256;
  localparam int unsigned ColW      = (MaxWidth > 1) ? $clog2(MaxWidth) : 1;
  localparam int unsigned WidthW    = $clog2(MaxWidth + 1);

  localparam int unsigned ValueW    = 32;
  localparam int unsigned ModeW     = 2;
  localparam int unsigned RowWidthW = 9;
  localparam int unsigned CfgIdxW   = 1;
  localparam int unsigned CfgDataW  = RowWidthW;

  localparam logic [ModeW-1:0] ModeMax   = 2'd0;
  localparam logic [ModeW-1:0] ModeSum   = 2'd1;
  localparam logic [ModeW-1:0] ModeFirst = 2'd2;

  localparam logic [CfgIdxW-1:0] CfgPoolMode = 1'b0;
  localparam logic [CfgIdxW-1:0] CfgRowWidth = 1'b1;

  // one element on its way from the column counter to the fold stage
  typedef struct packed {
    logic [ColW-1:0]          col;
    logic                     first;
    logic                     fin;
    logic                     last;
    logic signed [ValueW-1:0] value;
  } item_t;

endpackage

`default_nettype wire

FILE: hw/rtl/spmsf_in_if.sv
// ----------------------------------------------------------------------------
// spmsf_in_if
// input element channel: value and final row flag
// ----------------------------------------------------------------------------
`default_nettype none

interface spmsf_in_if;
  import spmsf_pkg::*;

  logic                     valid;
  logic                     ready;
  logic signed [ValueW-1:0] value;
  logic                     final_row;

  modport source (output valid, output value, output final_row, input ready);
  modport sink   (input valid, input value, input final_row, output ready);
endinterface

`default_nettype wire

FILE: hw/rtl/spmsf_out_if.sv
// ----------------------------------------------------------------------------
// spmsf_out_if
// pooled result channel: pooled value and last column flag
// ----------------------------------------------------------------------------
`default_nettype none

interface spmsf_out_if;
  import spmsf_pkg::*;

  logic                     valid;
  logic                     ready;
  logic signed [ValueW-1:0] pooled_value;
  logic                     row_last;

  modport source (output valid, output pooled_value, output row_last, input ready);
  modport sink   (input valid, input pooled_value, input row_last, output ready);
endinterface

`default_nettype wire

FILE: hw/rtl/spmsf_cfg_if.sv
// ----------------------------------------------------------------------------
// spmsf_cfg_if
// configuration write channel: register index and write data
// ----------------------------------------------------------------------------
`default_nettype none

interface spmsf_cfg_if;
  import spmsf_pkg::*;

  logic                valid;
  logic                ready;
  logic [CfgIdxW-1:0]  index;
  logic [CfgDataW-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

FILE: hw/rtl/segment_pool_max_sum_first_core.sv
// result: registered from the fold stage after a final row element word;
// throughput: one element word per cycle while no blocked result word holds
//   the fold stage; the accumulator ram is read on accept and written back
// reset: column 0, first row pending, max mode, row width 1; the accumulator
//   ram is not cleared, a sequence's first row loads it
// ----------------------------------------------------------------------------
// segment_pool_max_sum_first_core
// pools feature rows of a sequence into one row by max, saturating sum or
// first row, one accumulator per column in a ram
// ----------------------------------------------------------------------------
`default_nettype none

module segment_pool_max_sum_first_core (
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  spmsf_in_if.sink    in_i,
  spmsf_cfg_if.sink   cfg_i,
  spmsf_out_if.source out_o
);
  import spmsf_pkg::*;

  // element handed from the column counter to the fold stage
  item_t             item;
  logic              item_valid;
  logic              item_ready;
  logic [ModeW-1:0]  mode;

  // accumulator ram ports
  logic              ram_re;
  logic              ram_we;
  logic [ColW-1:0]   ram_waddr;
  logic [ValueW-1:0] ram_wdata;
  logic [ValueW-1:0] ram_rdata;

  // front end: config registers, column counter, first row flag
  spmsf_ctrl u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_i         (in_i),
    .cfg_i        (cfg_i),
    .item_ready_i (item_ready),
    .item_valid_o (item_valid),
    .item_o       (item),
    .mode_o       (mode)
  );

  // read the column accumulator as the element word is accepted
  assign ram_re = item_valid && item_ready;

  spmsf_ram #(
    .Width (ValueW),
    .Depth (MaxWidth)
  ) u_acc_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (item.col),
    .rdata_o (ram_rdata)
  );

  // fold stage: forward last write, fold, write back, register the result
  spmsf_fold u_fold (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .item_valid_i (item_valid),
    .item_i       (item),
    .item_ready_o (item_ready),
    .mode_i       (mode),
    .rdata_i      (ram_rdata),
    .we_o         (ram_we),
    .waddr_o      (ram_waddr),
    .wdata_o      (ram_wdata),
    .out_o        (out_o)
  );

endmodule

`default_nettype wire

FILE: hw/rtl/spmsf_ram.sv
// ----------------------------------------------------------------------------
// spmsf_ram
// generic single write, single read ram, registered read, read-first
// ----------------------------------------------------------------------------
`default_nettype none

module spmsf_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 256
) (
  input  wire logic                                     clk_i,
  input  wire logic                                     we_i,
  input  wire logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] waddr_i,
  input  wire logic [Width-1:0]                         wdata_i,
  input  wire logic                                     re_i,
  input  wire logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] raddr_i,
  output logic      [Width-1:0]                         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

FILE: hw/rtl/spmsf_ctrl.sv
// ----------------------------------------------------------------------------
// spmsf_ctrl
// configuration registers, column counter and first row tracking
// ----------------------------------------------------------------------------
`default_nettype none

module spmsf_ctrl (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  spmsf_in_if.sink                    in_i,
  spmsf_cfg_if.sink                   cfg_i,
  input  wire logic                   item_ready_i,
  output logic                        item_valid_o,
  output spmsf_pkg::item_t            item_o,
  output logic [spmsf_pkg::ModeW-1:0] mode_o
);
  import spmsf_pkg::*;

  logic [ModeW-1:0]     mode_q;
  logic [RowWidthW-1:0] row_width_q;
  logic [ColW-1:0]      col_q, col_d;
  logic                 first_q, first_d;
  logic [WidthW-1:0]    eff_w;
  logic [ColW-1:0]      col;
  logic                 last;
  logic                 accept;

  // clamp the row width to 1..MaxWidth
  always_comb begin
    if (row_width_q == '0) begin
      eff_w = WidthW'(1);
    end else if (32'(row_width_q) > 32'(MaxWidth)) begin
      eff_w = WidthW'(MaxWidth);
    end else begin
      eff_w = WidthW'(row_width_q);
    end
  end

  always_comb begin
    col = (WidthW'(col_q) >= eff_w) ? '0 : col_q;
    last = (WidthW'(col) == (eff_w - WidthW'(1)));
  end

  assign accept = in_i.valid && item_ready_i;

  always_comb begin
    col_d   = col_q;
    first_d = first_q;
    if (accept) begin
      if (last) begin
        col_d   = '0;
        first_d = in_i.final_row;
      end else begin
        col_d = ColW'(col + 1'b1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q   <= '0;
      first_q <= 1'b1;
    end else begin
      col_q   <= col_d;
      first_q <= first_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q      <= ModeMax;
      row_width_q <= RowWidthW'(1);
    end else if (cfg_i.valid) begin
      unique case (cfg_i.index)
        CfgPoolMode: mode_q      <= cfg_i.data[ModeW-1:0];
        CfgRowWidth: row_width_q <= cfg_i.data[RowWidthW-1:0];
        default: ;
      endcase
    end
  end

  assign cfg_i.ready  = 1'b1;
  assign in_i.ready   = item_ready_i;
  assign item_valid_o = in_i.valid;
  assign mode_o       = mode_q;

  always_comb begin
    item_o.col   = col;
    item_o.first = first_q;
    item_o.fin   = in_i.final_row;
    item_o.last  = last;
    item_o.value = in_i.value;
  end

endmodule

`default_nettype wire

FILE: hw/rtl/spmsf_fold.sv
// ----------------------------------------------------------------------------
// spmsf_fold
// accumulator fold stage with write forwarding and result register
// ----------------------------------------------------------------------------
`default_nettype none

module spmsf_fold (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           item_valid_i,
  input  wire spmsf_pkg::item_t               item_i,
  output logic                                item_ready_o,
  input  wire logic [spmsf_pkg::ModeW-1:0]    mode_i,
  input  wire logic [spmsf_pkg::ValueW-1:0]   rdata_i,
  output logic                                we_o,
  output logic [spmsf_pkg::ColW-1:0]          waddr_o,
  output logic [spmsf_pkg::ValueW-1:0]        wdata_o,
  spmsf_out_if.source                         out_o
);
  import spmsf_pkg::*;

  item_t                    s1_q;
  logic                     s1_valid_q;
  logic                     s1_go;
  logic                     wr_valid_q;
  logic [ColW-1:0]          wr_addr_q;
  logic signed [ValueW-1:0] wr_data_q;
  logic signed [ValueW-1:0] acc_old;
  logic signed [ValueW-1:0] acc_new;
  logic signed [ValueW:0]   sum;
  logic                     out_valid_q;
  logic signed [ValueW-1:0] out_value_q;
  logic                     out_last_q;

  // stage holds only when it has a result and the output register is blocked
  assign s1_go        = !s1_q.fin || !out_valid_q || out_o.ready;
  assign item_ready_o = !s1_valid_q || s1_go;

  // last write to the ram is never older than the ram data
  assign acc_old = (wr_valid_q && (wr_addr_q == s1_q.col)) ? wr_data_q : $signed(rdata_i);

  always_comb begin
    sum = {acc_old[ValueW-1], acc_old} + {s1_q.value[ValueW-1], s1_q.value};
    if (s1_q.first) begin
      acc_new = s1_q.value;
    end else begin
      case (mode_i)
        ModeMax: acc_new = (s1_q.value > acc_old) ? s1_q.value : acc_old;
        ModeSum: begin
          if (sum[ValueW] != sum[ValueW-1]) begin
            acc_new = sum[ValueW] ? {1'b1, {(ValueW-1){1'b0}}} : {1'b0, {(ValueW-1){1'b1}}};
          end else begin
            acc_new = sum[ValueW-1:0];
          end
        end
        default: acc_new = acc_old;
      endcase
    end
  end

  assign we_o    = s1_valid_q && s1_go;
  assign waddr_o = s1_q.col;
  assign wdata_o = acc_new;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      wr_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (item_ready_o) begin
        s1_valid_q <= item_valid_i;
      end
      if (we_o) begin
        wr_valid_q <= 1'b1;
      end
      if (we_o && s1_q.fin) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (item_ready_o && item_valid_i) begin
      s1_q <= item_i;
    end
    if (we_o) begin
      wr_addr_q <= s1_q.col;
      wr_data_q <= acc_new;
    end
    if (we_o && s1_q.fin) begin
      out_value_q <= acc_new;
      out_last_q  <= s1_q.last;
    end
  end

  assign out_o.valid        = out_valid_q;
  assign out_o.pooled_value = out_value_q;
  assign out_o.row_last     = out_last_q;

endmodule

`default_nettype wire

FILE: hw/rtl/spmsf_checker.sv
// ----------------------------------------------------------------------------
// spmsf_checker
// port level checks of the pooling block, bound to the top level
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module spmsf_checker (
  input wire logic                         clk_i,
  input wire logic                         rst_ni,
  input wire logic                         in_valid_i,
  input wire logic                         in_ready_i,
  input wire logic                         out_valid_i,
  input wire logic                         out_ready_i,
  input wire logic [spmsf_pkg::ValueW-1:0] out_value_i,
  input wire logic                         out_last_i
);
  import spmsf_pkg::*;

  logic in_acc;
  assign in_acc = in_valid_i && in_ready_i;

  // a blocked result word keeps its contents
  `SPMSF_ASSERT(a_out_hold, clk_i, rst_ni, (out_valid_i && !out_ready_i) |=> (out_valid_i && $stable(out_value_i) && $stable(out_last_i)), "stalled result word changed")

  // a fresh result word comes from an accepted element word, past the stage and output registers
  `SPMSF_ASSERT(a_out_latency, clk_i, rst_ni, $rose(out_valid_i) |-> $past(in_acc, 2), "result word without matching element word")

  // input stalls only behind a blocked result word
  `SPMSF_ASSERT(a_in_stall, clk_i, rst_ni, !in_ready_i |-> out_valid_i, "input stalled with output free")

  // no result word right out of reset
  `SPMSF_ASSERT_NR(a_reset_quiet, clk_i, !$past(rst_ni) |-> !out_valid_i, "result word during reset")

endmodule

bind segment_pool_max_sum_first_core spmsf_checker u_spmsf_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_i.valid),
  .in_ready_i  (in_i.ready),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .out_value_i (out_o.pooled_value),
  .out_last_i  (out_o.row_last)
);

`default_nettype wire

FILE: tb/pool_tracker_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pool_tracker_pkg
// column accumulator tracking and pooled word checking for the pooling core
// ----------------------------------------------------------------------------
package pool_tracker_pkg;
  import spmsf_pkg::*;

  typedef struct packed {
    logic signed [ValueW-1:0] pooled_value;
    logic                     row_last;
  } pooled_word_t;

  class pool_tracker;
    logic signed [ValueW-1:0] acc [MaxWidth];
    bit                       loaded [MaxWidth];
    int unsigned              col;
    bit                       first_row;
    logic [ModeW-1:0]         mode;
    logic [RowWidthW-1:0]     width;
    pooled_word_t             expected_pooled [$];
    int unsigned              mismatches;

    function new();
      foreach (loaded[i]) loaded[i] = 1'b0;
      col        = 0;
      first_row  = 1'b1;
      mode       = ModeMax;
      width      = RowWidthW'(1);
      mismatches = 0;
    endfunction

    // zero acts as one, anything past the ram depth as the ram depth
    function int unsigned effective_width(logic [RowWidthW-1:0] w);
      if (w == 0) return 1;
      if (w > MaxWidth) return MaxWidth;
      return 32'(w);
    endfunction

    function void write_reg(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] data);
      if (idx == CfgPoolMode) mode = data[ModeW-1:0];
      else if (idx == CfgRowWidth) width = data[RowWidthW-1:0];
    endfunction

    function bit at_sequence_start();
      return first_row && (col == 0 || col >= effective_width(width));
    endfunction

    // a new width must never make a later row read a column never loaded
    function bit width_safe(logic [RowWidthW-1:0] w);
      if (first_row) return 1'b1;
      for (int unsigned i = 0; i < effective_width(w); i++)
        if (!loaded[i]) return 1'b0;
      return 1'b1;
    endfunction

    function void note_element(logic signed [ValueW-1:0] v, logic fin);
      int unsigned  w;
      int unsigned  c;
      longint       s;
      pooled_word_t r;
      w = effective_width(width);
      c = (col >= w) ? 0 : col;
      if (first_row) begin
        acc[c]    = v;
        loaded[c] = 1'b1;
      end else if (mode == ModeMax) begin
        if (v > acc[c]) acc[c] = v;
      end else if (mode == ModeSum) begin
        s = longint'(acc[c]) + longint'(v);
        if (s > 64'sd2147483647) s = 64'sd2147483647;
        else if (s < -64'sd2147483648) s = -64'sd2147483648;
        acc[c] = s[ValueW-1:0];
      end
      if (fin) begin
        r.pooled_value = acc[c];
        r.row_last     = (c == w - 1);
        expected_pooled.push_back(r);
      end
      if (c == w - 1) begin
        col       = 0;
        first_row = fin;
      end else begin
        col = c + 1;
      end
    endfunction

    task flag_mismatch(string msg);
      $display("mismatch: %s", msg);
      mismatches++;
    endtask

    task check_pooled(logic signed [ValueW-1:0] pv, logic rl);
      pooled_word_t e;
      if (expected_pooled.size() == 0) begin
        flag_mismatch($sformatf("unexpected word pooled_value=%h row_last=%b", pv, rl));
        return;
      end
      e = expected_pooled.pop_front();
      if (pv !== e.pooled_value)
        flag_mismatch($sformatf("pooled_value %h, expected %h", pv, e.pooled_value));
      if (rl !== e.row_last)
        flag_mismatch($sformatf("row_last %b, expected %b", rl, e.row_last));
    endtask
  endclass

endpackage

FILE: tb/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// regression for the segment pooling core: directed corner sequences, then
// random well-formed and broken sequences under random stalls on both sides
// ----------------------------------------------------------------------------
module tb;
  import spmsf_pkg::*;
  import pool_tracker_pkg::*;

  localparam int unsigned ItemTarget    = 1650;
  localparam int unsigned StallLimit    = 5000;
  localparam int unsigned HoldOffCycles = 300;
  // an element word without a result leaves the pipe in the cycle after it is
  // accepted, so the settle wait covers it with margin
  localparam int unsigned SettleCycles  = 4;

  localparam logic [ModeW-1:0]        ModeUnused = 2'd3;
  localparam logic signed [ValueW-1:0] ValMax    = 32'sh7FFF_FFFF;
  localparam logic signed [ValueW-1:0] ValMin    = 32'sh8000_0000;

  logic clk;
  logic rst_n;

  spmsf_in_if  in_ch ();
  spmsf_cfg_if cfg_ch ();
  spmsf_out_if out_ch ();

  segment_pool_max_sum_first_core dut (
    .clk_i (clk),
    .rst_ni(rst_n),
    .in_i  (in_ch),
    .cfg_i (cfg_ch),
    .out_o (out_ch)
  );

  pool_tracker tracker;
  int unsigned send_idle_pct = 26;
  int unsigned recv_idle_pct = 63;
  bit          hold_off      = 1'b0;
  int unsigned items_sent    = 0;
  int unsigned quiet_cycles  = 0;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // result side ready, dropped at random and held low during a hold-off
  initial begin
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      out_ch.ready <= !hold_off && ($urandom_range(0, 99) >= recv_idle_pct);
    end
  end

  // every accepted word goes to the tracker at the edge that accepts it
  always @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) tracker.note_element(in_ch.value, in_ch.final_row);
    if (out_ch.valid && out_ch.ready) tracker.check_pooled(out_ch.pooled_value, out_ch.row_last);
    if (cfg_ch.valid && cfg_ch.ready) tracker.write_reg(cfg_ch.index, cfg_ch.data);
  end

  // watchdog: too long without any word moving on any channel
  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == StallLimit) begin
      $display("segment_pool_max_sum_first_core regression: fail");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // mix of extremes, small values that rarely saturate, and full range
  function automatic logic signed [ValueW-1:0] rand_value();
    case ($urandom_range(0, 7))
      0:       return ValMax;
      1:       return ValMin;
      2:       return '0;
      3:       return '1;
      4, 5:    return int'($urandom_range(0, 2097152)) - 1048576;
      default: return $urandom;
    endcase
  endfunction

  // called at a falling edge, returns at the falling edge after acceptance
  // with valid still high, so the next word follows without a gap
  task automatic send_element(logic signed [ValueW-1:0] v, logic fin);
    if ($urandom_range(0, 99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      do @(negedge clk); while ($urandom_range(0, 99) < send_idle_pct);
    end
    in_ch.valid     <= 1'b1;
    in_ch.value     <= v;
    in_ch.final_row <= fin;
    do @(posedge clk); while (in_ch.ready !== 1'b1);
    @(negedge clk);
    items_sent++;
  endtask

  task automatic send_row(int unsigned n, logic fin);
    repeat (n) send_element(rand_value(), fin);
  endtask

  // finish the row in progress as a final row so a fresh sequence can start
  task automatic align_to_sequence();
    while (!tracker.at_sequence_start()) send_element(rand_value(), 1'b1);
  endtask

  // sender parks until every pooled word is back, then lets the pipe settle,
  // since element words without a result may still be in flight
  task automatic wait_for_results();
    in_ch.valid <= 1'b0;
    while (tracker.expected_pooled.size() != 0) @(negedge clk);
    repeat (SettleCycles) @(negedge clk);
  endtask

  // leaves valid high so back to back writes keep it up
  task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] d);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= d;
    do @(posedge clk); while (cfg_ch.ready !== 1'b1);
    @(negedge clk);
  endtask

  // registers only change once the block has gone idle
  task automatic reconfigure(bit wr_mode, logic [CfgDataW-1:0] mode_d,
                             bit wr_width, logic [CfgDataW-1:0] width_d);
    if (!wr_mode && !wr_width) return;
    wait_for_results();
    if (wr_mode) write_reg(CfgPoolMode, mode_d);
    if (wr_width) write_reg(CfgRowWidth, width_d);
    cfg_ch.valid <= 1'b0;
  endtask

  initial begin
    int unsigned          chunk;
    int unsigned          ew;
    int unsigned          rows;
    int unsigned          pick;
    bit                   wr_mode;
    bit                   wr_width;
    logic [CfgDataW-1:0]  mode_d;
    logic [CfgDataW-1:0]  width_d;

    tracker         = new();
    rst_n           = 1'b0;
    in_ch.valid     = 1'b0;
    in_ch.value     = '0;
    in_ch.final_row = 1'b0;
    cfg_ch.valid    = 1'b0;
    cfg_ch.index    = CfgPoolMode;
    cfg_ch.data     = '0;
    repeat (4) @(negedge clk);
    rst_n <= 1'b1;

    // ---- directed part ----

    // reset config: max mode, one column, a single final row
    send_element(ValMax, 1'b1);

    // max over three one-column rows, with the most negative value in between
    send_element(-32'sd7, 1'b0);
    send_element(ValMin, 1'b0);
    send_element(ValMax, 1'b1);

    // sum saturating to both ends of the range
    reconfigure(1'b1, CfgDataW'(ModeSum), 1'b1, CfgDataW'(2));
    send_element(ValMax, 1'b0);
    send_element(ValMin, 1'b0);
    send_element(32'sd1, 1'b1);
    send_element(-32'sd1, 1'b1);

    // first mode keeps the first row
    reconfigure(1'b1, CfgDataW'(ModeFirst), 1'b0, '0);
    send_element(32'sd10, 1'b0);
    send_element(32'sd20, 1'b0);
    send_element(32'sd30, 1'b1);
    send_element(32'sd40, 1'b1);

    // unused mode code behaves like first mode
    reconfigure(1'b1, CfgDataW'(ModeUnused), 1'b1, CfgDataW'(1));
    send_element(32'sd5, 1'b0);
    send_element(32'sd6, 1'b1);

    // final_row flags that disagree inside a row: only the last column's
    // flag ends the sequence, each element answers for itself
    reconfigure(1'b1, CfgDataW'(ModeMax), 1'b1, CfgDataW'(2));
    send_element(32'sd1, 1'b1);
    send_element(32'sd2, 1'b0);
    send_element(32'sd3, 1'b0);
    send_element(32'sd4, 1'b1);

    // width past the ram depth, then narrowed mid-row so the column counter
    // already sits beyond the new width and wraps to column 0
    reconfigure(1'b0, '0, 1'b1, '1);
    send_element(32'sd11, 1'b0);
    send_element(32'sd12, 1'b0);
    send_element(32'sd13, 1'b0);
    reconfigure(1'b0, '0, 1'b1, CfgDataW'(2));
    send_element(32'sd9, 1'b1);
    send_element(32'sd8, 1'b1);

    // width zero acts as one column
    reconfigure(1'b0, '0, 1'b1, '0);
    send_element(ValMin, 1'b1);

    // ---- random part ----
    // idle mix moves through three stages as items go by
    chunk = 0;
    while (items_sent < ItemTarget) begin
      if (items_sent < ItemTarget / 3) begin
        send_idle_pct = 26;
        recv_idle_pct = 63;
      end else if (items_sent < 2 * ItemTarget / 3) begin
        send_idle_pct = 63;
        recv_idle_pct = 26;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end

      wr_mode  = 1'($urandom_range(0, 1));
      wr_width = 1'($urandom_range(0, 1));
      mode_d   = CfgDataW'($urandom_range(0, 3));
      // unused upper data bits on a mode write now and then
      if ($urandom_range(0, 3) == 0) mode_d[CfgDataW-1:ModeW] = (CfgDataW-ModeW)'($urandom);
      // mostly narrow rows, wide ones rarely since they cost many words
      pick = $urandom_range(0, 99);
      if (pick < 75) width_d = CfgDataW'($urandom_range(1, 8));
      else if (pick < 85) width_d = CfgDataW'($urandom_range(9, 16));
      else if (pick < 90) width_d = '0;
      else if (pick < 95) width_d = CfgDataW'($urandom_range(17, 255));
      else width_d = CfgDataW'($urandom_range(256, 511));

      // usually change width at a sequence boundary, sometimes mid-row
      if (wr_width && $urandom_range(0, 4) != 0) align_to_sequence();
      if (!tracker.width_safe(width_d)) wr_width = 1'b0;
      reconfigure(wr_mode, mode_d, wr_width, width_d);

      // long receiver hold-off while the sender keeps offering words
      if (chunk % 12 == 1) begin
        fork
          begin
            @(posedge clk);
            hold_off = 1'b1;
            repeat (HoldOffCycles) @(posedge clk);
            hold_off = 1'b0;
          end
        join_none
      end

      ew = tracker.effective_width(tracker.width);
      if (ew > 16) begin
        // wide rows: a single one-row sequence
        align_to_sequence();
        send_row(ew, 1'b1);
      end else begin
        repeat ($urandom_range(1, 4)) begin
          if ($urandom_range(0, 99) < 15) begin
            // broken sequence: random length, random flags
            repeat ($urandom_range(1, 2 * ew))
              send_element(rand_value(), 1'($urandom_range(0, 1)));
          end else begin
            align_to_sequence();
            rows = $urandom_range(1, 4);
            for (int unsigned r = 1; r <= rows; r++) send_row(ew, r == rows);
          end
        end
      end
      chunk++;
    end

    wait_for_results();
    if (tracker.mismatches == 0) begin
      $display("segment_pool_max_sum_first_core regression: pass");
    end else begin
      $display("segment_pool_max_sum_first_core regression: fail");
    end
    $finish;
  end

endmodule

FILE: segment_pool_max_sum_first_core.f
+incdir+hw/rtl
hw/rtl/spmsf_pkg.sv
hw/rtl/spmsf_in_if.sv
hw/rtl/spmsf_out_if.sv
hw/rtl/spmsf_cfg_if.sv
hw/rtl/spmsf_ram.sv
hw/rtl/spmsf_ctrl.sv
hw/rtl/spmsf_fold.sv
hw/rtl/segment_pool_max_sum_first_core.sv
hw/rtl/spmsf_checker.sv
tb/pool_tracker_pkg.sv
tb/tb.sv
